FILE: rtl/core/puvp_pkg.sv
// Shared types and constants for the planar UV projector.
// Used by puvp_muldiv and planar_uv_projector; depends on nothing.
package puvp_pkg;

    localparam int WIDE_W = 128;
    localparam int CNT_W  = 7;
    localparam logic [CNT_W-1:0] MUL_LAST = 7'd63;
    localparam logic [CNT_W-1:0] DIV_LAST = 7'd127;

    typedef enum logic
    {
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed
    {
        logic start;
        op_t  op;
    } muldiv_req_t;

endpackage

FILE: rtl/core/puvp_muldiv.sv
// Shared iterative arithmetic unit: signed 64x64 shift-add multiply and
// signed fixed-point restoring divide, both on one 129-bit adder.
// Depends on puvp_pkg.
module puvp_muldiv #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  puvp_pkg::muldiv_req_t req,
    input  logic [127:0]         a,
    input  logic [127:0]         b,
    output logic [127:0]         res,
    output logic                 done
);
    import puvp_pkg::*;

    typedef enum logic [1:0]
    {
        M_IDLE,
        M_RUN,
        M_FIX
    } mstate_t;

    mstate_t            state_reg;
    op_t                op_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [WIDE_W-1:0]  acc_reg;   // product / remainder
    logic [WIDE_W-1:0]  sh_reg;    // multiplicand / dividend
    logic [WIDE_W-1:0]  qm_reg;    // multiplier / quotient
    logic [WIDE_W-1:0]  d_reg;
    logic [WIDE_W-1:0]  res_reg;
    logic               done_reg;

    logic [WIDE_W-1:0]  abs_a;
    logic [WIDE_W-1:0]  abs_b;
    logic [WIDE_W-1:0]  rs;
    logic [WIDE_W-1:0]  opx;
    logic [WIDE_W-1:0]  opy;
    logic               cin;
    logic [WIDE_W:0]    sum;
    logic [WIDE_W-1:0]  fix_val;

    assign abs_a   = a[127] ? (~a + 128'd1) : a;
    assign abs_b   = b[127] ? (~b + 128'd1) : b;
    assign rs      = {acc_reg[126:0], sh_reg[127]};
    assign fix_val = (op_reg == OP_MUL) ? acc_reg : qm_reg;

    always_comb
    begin
        opx = acc_reg;
        opy = '0;
        cin = 1'b0;
        case (state_reg)
            M_RUN:
            begin
                if (op_reg == OP_MUL)
                begin
                    opx = acc_reg;
                    opy = qm_reg[0] ? sh_reg : '0;
                end
                else
                begin
                    opx = rs;
                    opy = ~d_reg;
                    cin = 1'b1;
                end
            end
            M_FIX:
            begin
                opx = fix_val ^ {WIDE_W{neg_reg}};
                cin = neg_reg;
            end
            default:
            begin
                opx = acc_reg;
            end
        endcase
    end

    assign sum = {1'b0, opx} + {1'b0, opy} + {{WIDE_W{1'b0}}, cin};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            op_reg    <= OP_MUL;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            sh_reg    <= '0;
            qm_reg    <= '0;
            d_reg     <= '0;
            res_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg  <= req.op;
                        neg_reg <= a[127] ^ b[127];
                        acc_reg <= '0;
                        d_reg   <= abs_b;
                        if (req.op == OP_MUL)
                        begin
                            sh_reg  <= {64'd0, abs_a[63:0]};
                            qm_reg  <= {64'd0, abs_b[63:0]};
                            cnt_reg <= MUL_LAST;
                        end
                        else
                        begin
                            sh_reg  <= abs_a << FRAC_BITS;
                            qm_reg  <= '0;
                            cnt_reg <= DIV_LAST;
                        end
                        state_reg <= M_RUN;
                    end
                end
                M_RUN:
                begin
                    if (op_reg == OP_MUL)
                    begin
                        acc_reg <= sum[127:0];
                        sh_reg  <= {sh_reg[126:0], 1'b0};
                        qm_reg  <= {1'b0, qm_reg[127:1]};
                    end
                    else
                    begin
                        // carry out means no borrow: remainder >= divisor
                        acc_reg <= sum[128] ? sum[127:0] : rs;
                        sh_reg  <= {sh_reg[126:0], 1'b0};
                        qm_reg  <= {qm_reg[126:0], sum[128]};
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= M_FIX;
                    end
                end
                M_FIX:
                begin
                    res_reg   <= sum[127:0];
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign res  = res_reg;
    assign done = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == M_IDLE)
        else $error("muldiv started while busy");

    a_done_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == M_FIX))
        else $error("done without sign fix-up");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == M_RUN && op_reg == OP_MUL) |-> cnt_reg <= MUL_LAST)
        else $error("multiply ran past 64 steps");

endmodule

FILE: rtl/core/planar_uv_projector.sv
// Top level of the planar UV projector: set-up registers, sequencer and
// output register around the shared puvp_muldiv unit. Depends on puvp_pkg.
//
// Input channel (vtx_valid/vtx_stall) carries action, x, y, z and base.
// Actions 0..2 load the u axis and base, the v axis and base, or the origin;
// they give no result. Action 3 projects a vertex and gives one result on
// the output channel (uv_valid/uv_stall): u, v, clipped and singular.
// A projection runs the shared multiplier/divider, one bit per cycle, for
// each 64x64 multiply and each 128-bit divide. Orthogonal axes: 15
// multiplies and up to 2 divides. Skewed axes: 21 multiplies and 2
// divides; a singular basis ends after the determinant.
// vtx_stall is high while a projection runs, so one vertex is in flight.
// The result sits in an output register; the next item may be accepted
// while it waits, and a projection finishing while uv_stall holds waits
// for the register to drain. Reset clears all axes, origin and bases to
// zero and empties the output register.
module planar_uv_projector #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vtx_valid,
    output logic               vtx_stall,
    input  logic [1:0]         action,
    input  logic signed [31:0] x,
    input  logic signed [31:0] y,
    input  logic signed [31:0] z,
    input  logic signed [31:0] base,
    output logic               uv_valid,
    input  logic               uv_stall,
    output logic signed [31:0] u,
    output logic signed [31:0] v,
    output logic               clipped,
    output logic               singular
);
    import puvp_pkg::*;

    localparam logic [1:0] ACT_LOAD_U = 2'd0;
    localparam logic [1:0] ACT_LOAD_V = 2'd1;
    localparam logic [1:0] ACT_ORIGIN = 2'd2;
    localparam logic [1:0] ACT_PROJ   = 2'd3;

    // |U.V| * 1e6 < 2^F  <=>  |U.V| <= (2^F - 1) / 1e6
    localparam longint ORTH_LIM = ((64'sd1 <<< FRAC_BITS) - 64'sd1) / 64'sd1000000;
    localparam logic signed [127:0] ORTH_HI = 128'(ORTH_LIM);
    localparam logic signed [127:0] ORTH_LO = -128'(ORTH_LIM);
    localparam int UP_SH = (FRAC_BITS >= 12) ? FRAC_BITS - 12 : 0;
    localparam int DN_SH = (FRAC_BITS < 12) ? 12 - FRAC_BITS : 0;

    localparam logic [4:0] ST_UR0    = 5'd0;
    localparam logic [4:0] ST_UR1    = 5'd1;
    localparam logic [4:0] ST_UR2    = 5'd2;
    localparam logic [4:0] ST_VR0    = 5'd3;
    localparam logic [4:0] ST_VR1    = 5'd4;
    localparam logic [4:0] ST_VR2    = 5'd5;
    localparam logic [4:0] ST_UU0    = 5'd6;
    localparam logic [4:0] ST_UU1    = 5'd7;
    localparam logic [4:0] ST_UU2    = 5'd8;
    localparam logic [4:0] ST_VV0    = 5'd9;
    localparam logic [4:0] ST_VV1    = 5'd10;
    localparam logic [4:0] ST_VV2    = 5'd11;
    localparam logic [4:0] ST_UV0    = 5'd12;
    localparam logic [4:0] ST_UV1    = 5'd13;
    localparam logic [4:0] ST_UV2    = 5'd14;
    localparam logic [4:0] ST_ORTH   = 5'd15;
    localparam logic [4:0] ST_DIVU_O = 5'd16;
    localparam logic [4:0] ST_DIVV_O = 5'd17;
    localparam logic [4:0] ST_DET0   = 5'd18;
    localparam logic [4:0] ST_DET1   = 5'd19;
    localparam logic [4:0] ST_DETCHK = 5'd20;
    localparam logic [4:0] ST_NU0    = 5'd21;
    localparam logic [4:0] ST_NU1    = 5'd22;
    localparam logic [4:0] ST_DIVU   = 5'd23;
    localparam logic [4:0] ST_NV0    = 5'd24;
    localparam logic [4:0] ST_NV1    = 5'd25;
    localparam logic [4:0] ST_DIVV   = 5'd26;

    typedef enum logic [3:0]
    {
        SRC_U0, SRC_U1, SRC_U2,
        SRC_V0, SRC_V1, SRC_V2,
        SRC_R0, SRC_R1, SRC_R2,
        SRC_PU, SRC_PV, SRC_M2U, SRC_M2V, SRC_DP,
        SRC_ACC, SRC_DET
    } src_t;

    typedef enum logic [1:0]
    {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } accm_t;

    typedef struct packed
    {
        op_t   op;
        src_t  a;
        src_t  b;
        accm_t accm;
    } uop_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_RESULT
    } state_t;

    function automatic uop_t uop_of(input logic [4:0] pc);
        uop_t o;
        o = '{op: OP_MUL, a: SRC_ACC, b: SRC_ACC, accm: ACC_LOAD};
        case (pc)
            ST_UR0:    o = '{OP_MUL, SRC_U0,  SRC_R0,  ACC_LOAD};
            ST_UR1:    o = '{OP_MUL, SRC_U1,  SRC_R1,  ACC_ADD};
            ST_UR2:    o = '{OP_MUL, SRC_U2,  SRC_R2,  ACC_ADD};
            ST_VR0:    o = '{OP_MUL, SRC_V0,  SRC_R0,  ACC_LOAD};
            ST_VR1:    o = '{OP_MUL, SRC_V1,  SRC_R1,  ACC_ADD};
            ST_VR2:    o = '{OP_MUL, SRC_V2,  SRC_R2,  ACC_ADD};
            ST_UU0:    o = '{OP_MUL, SRC_U0,  SRC_U0,  ACC_LOAD};
            ST_UU1:    o = '{OP_MUL, SRC_U1,  SRC_U1,  ACC_ADD};
            ST_UU2:    o = '{OP_MUL, SRC_U2,  SRC_U2,  ACC_ADD};
            ST_VV0:    o = '{OP_MUL, SRC_V0,  SRC_V0,  ACC_LOAD};
            ST_VV1:    o = '{OP_MUL, SRC_V1,  SRC_V1,  ACC_ADD};
            ST_VV2:    o = '{OP_MUL, SRC_V2,  SRC_V2,  ACC_ADD};
            ST_UV0:    o = '{OP_MUL, SRC_U0,  SRC_V0,  ACC_LOAD};
            ST_UV1:    o = '{OP_MUL, SRC_U1,  SRC_V1,  ACC_ADD};
            ST_UV2:    o = '{OP_MUL, SRC_U2,  SRC_V2,  ACC_ADD};
            ST_DIVU_O: o = '{OP_DIV, SRC_PU,  SRC_M2U, ACC_LOAD};
            ST_DIVV_O: o = '{OP_DIV, SRC_PV,  SRC_M2V, ACC_LOAD};
            ST_DET0:   o = '{OP_MUL, SRC_M2U, SRC_M2V, ACC_LOAD};
            ST_DET1:   o = '{OP_MUL, SRC_DP,  SRC_DP,  ACC_SUB};
            ST_NU0:    o = '{OP_MUL, SRC_PU,  SRC_M2V, ACC_LOAD};
            ST_NU1:    o = '{OP_MUL, SRC_PV,  SRC_DP,  ACC_SUB};
            ST_DIVU:   o = '{OP_DIV, SRC_ACC, SRC_DET, ACC_LOAD};
            ST_NV0:    o = '{OP_MUL, SRC_PV,  SRC_M2U, ACC_LOAD};
            ST_NV1:    o = '{OP_MUL, SRC_PU,  SRC_DP,  ACC_SUB};
            ST_DIVV:   o = '{OP_DIV, SRC_ACC, SRC_DET, ACC_LOAD};
            default:   o = '{OP_MUL, SRC_ACC, SRC_ACC, ACC_LOAD};
        endcase
        return o;
    endfunction

    function automatic logic [127:0] sx32(input logic [31:0] val);
        return {{96{val[31]}}, val};
    endfunction

    function automatic logic [127:0] sx33(input logic [32:0] val);
        return {{95{val[32]}}, val};
    endfunction

    function automatic logic [127:0] base_q(input logic [31:0] b);
        logic signed [127:0] w;
        w = $signed(sx32(b));
        if (FRAC_BITS >= 12)
        begin
            return w <<< UP_SH;
        end
        return w >>> DN_SH;
    endfunction

    function automatic logic [31:0] sat32(input logic [127:0] val);
        if (val[127:31] == {97{val[127]}})
        begin
            return val[31:0];
        end
        return val[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic logic fits32(input logic [127:0] val);
        return val[127:31] == {97{val[127]}};
    endfunction

    state_t             state_reg;
    logic [4:0]         pc_reg;
    logic signed [31:0] u_axis_reg [3];
    logic signed [31:0] v_axis_reg [3];
    logic signed [31:0] org_reg    [3];
    logic [31:0]        u_off_reg;
    logic [31:0]        v_off_reg;
    logic [32:0]        r_reg      [3];
    logic [127:0]       acc_reg;
    logic [127:0]       pu_reg;
    logic [127:0]       pv_reg;
    logic [127:0]       m2u_reg;
    logic [127:0]       m2v_reg;
    logic [127:0]       dp_reg;
    logic [127:0]       det_reg;
    logic [127:0]       pju_reg;
    logic [127:0]       pjv_reg;
    logic               sing_reg;
    logic               uv_valid_reg;
    logic [31:0]        u_reg;
    logic [31:0]        v_reg;
    logic               clipped_reg;
    logic               singular_reg;

    uop_t               uop;
    muldiv_req_t        mreq;
    logic [127:0]       opa;
    logic [127:0]       opb;
    logic [127:0]       mres;
    logic               mdone;
    logic [127:0]       acc_next;
    logic [127:0]       dot_next;
    logic               orth;
    logic               skip;
    logic               out_free;
    logic [127:0]       sum_u;
    logic [127:0]       sum_v;
    logic               vtx_take;

    function automatic logic [127:0] pick(input src_t s);
        case (s)
            SRC_U0:  return sx32(u_axis_reg[0]);
            SRC_U1:  return sx32(u_axis_reg[1]);
            SRC_U2:  return sx32(u_axis_reg[2]);
            SRC_V0:  return sx32(v_axis_reg[0]);
            SRC_V1:  return sx32(v_axis_reg[1]);
            SRC_V2:  return sx32(v_axis_reg[2]);
            SRC_R0:  return sx33(r_reg[0]);
            SRC_R1:  return sx33(r_reg[1]);
            SRC_R2:  return sx33(r_reg[2]);
            SRC_PU:  return pu_reg;
            SRC_PV:  return pv_reg;
            SRC_M2U: return m2u_reg;
            SRC_M2V: return m2v_reg;
            SRC_DP:  return dp_reg;
            SRC_DET: return det_reg;
            default: return acc_reg;
        endcase
    endfunction

    assign uop = uop_of(pc_reg);
    assign opa = pick(uop.a);
    assign opb = pick(uop.b);

    // zero squared length on the orthogonal path skips its divide
    assign skip = (pc_reg == ST_DIVU_O && m2u_reg == '0)
               || (pc_reg == ST_DIVV_O && m2v_reg == '0);

    assign mreq.start = (state_reg == S_ISSUE) && !skip
                     && (pc_reg != ST_ORTH) && (pc_reg != ST_DETCHK);
    assign mreq.op    = uop.op;

    always_comb
    begin
        case (uop.accm)
            ACC_ADD: acc_next = acc_reg + mres;
            ACC_SUB: acc_next = acc_reg - mres;
            default: acc_next = mres;
        endcase
    end

    assign dot_next = $signed(acc_next) >>> FRAC_BITS;
    assign orth     = ($signed(dp_reg) <= ORTH_HI) && ($signed(dp_reg) >= ORTH_LO);
    assign out_free = !uv_valid_reg || !uv_stall;
    assign sum_u    = pju_reg + base_q(u_off_reg);
    assign sum_v    = pjv_reg + base_q(v_off_reg);
    assign vtx_stall = (state_reg != S_IDLE);
    assign vtx_take  = vtx_valid && !vtx_stall;

    puvp_muldiv #(
        .FRAC_BITS(FRAC_BITS)
    ) u_muldiv (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mreq),
        .a    (opa),
        .b    (opb),
        .res  (mres),
        .done (mdone)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pc_reg       <= ST_UR0;
            for (int i = 0; i < 3; i++)
            begin
                u_axis_reg[i] <= '0;
                v_axis_reg[i] <= '0;
                org_reg[i]    <= '0;
                r_reg[i]      <= '0;
            end
            u_off_reg    <= '0;
            v_off_reg    <= '0;
            acc_reg      <= '0;
            pu_reg       <= '0;
            pv_reg       <= '0;
            m2u_reg      <= '0;
            m2v_reg      <= '0;
            dp_reg       <= '0;
            det_reg      <= '0;
            pju_reg      <= '0;
            pjv_reg      <= '0;
            sing_reg     <= 1'b0;
            uv_valid_reg <= 1'b0;
            u_reg        <= '0;
            v_reg        <= '0;
            clipped_reg  <= 1'b0;
            singular_reg <= 1'b0;
        end
        else
        begin
            // in the result state a drained register is refilled below
            if (uv_valid_reg && !uv_stall && state_reg != S_RESULT)
            begin
                uv_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (vtx_take)
                    begin
                        case (action)
                            ACT_LOAD_U:
                            begin
                                u_axis_reg[0] <= x;
                                u_axis_reg[1] <= y;
                                u_axis_reg[2] <= z;
                                u_off_reg     <= base;
                            end
                            ACT_LOAD_V:
                            begin
                                v_axis_reg[0] <= x;
                                v_axis_reg[1] <= y;
                                v_axis_reg[2] <= z;
                                v_off_reg     <= base;
                            end
                            ACT_ORIGIN:
                            begin
                                org_reg[0] <= x;
                                org_reg[1] <= y;
                                org_reg[2] <= z;
                            end
                            ACT_PROJ:
                            begin
                                r_reg[0]  <= {x[31], x} - {org_reg[0][31], org_reg[0]};
                                r_reg[1]  <= {y[31], y} - {org_reg[1][31], org_reg[1]};
                                r_reg[2]  <= {z[31], z} - {org_reg[2][31], org_reg[2]};
                                pc_reg    <= ST_UR0;
                                sing_reg  <= 1'b0;
                                state_reg <= S_ISSUE;
                            end
                            default:
                            begin
                                pc_reg <= ST_UR0;
                            end
                        endcase
                    end
                end
                S_ISSUE:
                begin
                    if (pc_reg == ST_ORTH)
                    begin
                        pc_reg <= orth ? ST_DIVU_O : ST_DET0;
                    end
                    else if (pc_reg == ST_DETCHK)
                    begin
                        if (det_reg == '0)
                        begin
                            sing_reg  <= 1'b1;
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            pc_reg <= pc_reg + 5'd1;
                        end
                    end
                    else if (skip)
                    begin
                        if (pc_reg == ST_DIVU_O)
                        begin
                            pju_reg <= '0;
                            pc_reg  <= pc_reg + 5'd1;
                        end
                        else
                        begin
                            pjv_reg   <= '0;
                            state_reg <= S_RESULT;
                        end
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (mdone)
                    begin
                        if (uop.op == OP_MUL)
                        begin
                            acc_reg <= acc_next;
                            case (pc_reg)
                                ST_UR2:  pu_reg  <= dot_next;
                                ST_VR2:  pv_reg  <= dot_next;
                                ST_UU2:  m2u_reg <= dot_next;
                                ST_VV2:  m2v_reg <= dot_next;
                                ST_UV2:  dp_reg  <= dot_next;
                                ST_DET1: det_reg <= acc_next;
                                default: ;
                            endcase
                            pc_reg    <= pc_reg + 5'd1;
                            state_reg <= S_ISSUE;
                        end
                        else if (pc_reg == ST_DIVU_O || pc_reg == ST_DIVU)
                        begin
                            pju_reg   <= mres;
                            pc_reg    <= pc_reg + 5'd1;
                            state_reg <= S_ISSUE;
                        end
                        else
                        begin
                            pjv_reg   <= mres;
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        uv_valid_reg <= 1'b1;
                        singular_reg <= sing_reg;
                        if (sing_reg)
                        begin
                            u_reg       <= '0;
                            v_reg       <= '0;
                            clipped_reg <= 1'b0;
                        end
                        else
                        begin
                            u_reg       <= sat32(sum_u);
                            v_reg       <= sat32(sum_v);
                            clipped_reg <= !fits32(sum_u) || !fits32(sum_v);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign uv_valid = uv_valid_reg;
    assign u        = u_reg;
    assign v        = v_reg;
    assign clipped  = clipped_reg;
    assign singular = singular_reg;

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (uv_valid_reg && singular_reg) |-> (u_reg == '0 && v_reg == '0 && !clipped_reg))
        else $error("singular result carries non-zero coordinates");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(uv_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result raised outside result state");

    a_issue_only: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.start |-> (state_reg == S_ISSUE && pc_reg <= ST_DIVV))
        else $error("arithmetic started outside issue step");

endmodule

FILE: tb/uv_projection_checker.sv
// Checker for the planar UV projector: watches both channels, predicts each
// projection in 128-bit arithmetic and compares it field by field.
// Depends on nothing but the port widths of planar_uv_projector.
module uv_projection_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vtx_valid,
    input  logic               vtx_stall,
    input  logic [1:0]         action,
    input  logic signed [31:0] x,
    input  logic signed [31:0] y,
    input  logic signed [31:0] z,
    input  logic signed [31:0] base,
    input  logic               uv_valid,
    input  logic               uv_stall,
    input  logic signed [31:0] u,
    input  logic signed [31:0] v,
    input  logic               clipped,
    input  logic               singular,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_U_AXIS = 2'd0;
    localparam logic [1:0] ACT_V_AXIS = 2'd1;
    localparam logic [1:0] ACT_ORIGIN = 2'd2;
    localparam logic [1:0] ACT_PROJECT = 2'd3;

    typedef struct packed
    {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               clipped;
        logic               singular;
    } uv_result_t;

    typedef logic signed [127:0] wide_t;

    logic signed [31:0] ax_u [3];
    logic signed [31:0] ax_v [3];
    logic signed [31:0] org [3];
    logic signed [31:0] base_u, base_v;
    uv_result_t         expected_uv [$];

    function automatic wide_t dot_q(input wide_t a0, a1, a2, b0, b1, b2);
        wide_t s;
        s = a0 * b0 + a1 * b1 + a2 * b2;
        return s >>> FRAC_BITS;
    endfunction

    // (num << FRAC_BITS) / den, truncated toward zero
    function automatic wide_t quot_q(input wide_t num, input wide_t den);
        wide_t an, ad, q;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        q = wide_t'((an << FRAC_BITS) / ad);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic wide_t base_to_q(input logic signed [31:0] b);
        wide_t w;
        w = b;
        if (FRAC_BITS >= 12)
            return w <<< (FRAC_BITS - 12);
        return w >>> (12 - FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] clamp32(input wide_t a, inout logic clip);
        if (a > 128'sd2147483647)
        begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (a < -128'sd2147483648)
        begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return a[31:0];
    endfunction

    function automatic uv_result_t project_vertex(input logic signed [31:0] px, py, pz);
        wide_t r0, r1, r2, pu, pv, m2u, m2v, dp, dm, det, qu, qv;
        uv_result_t res;
        logic clip;
        r0 = wide_t'(px) - wide_t'(org[0]);
        r1 = wide_t'(py) - wide_t'(org[1]);
        r2 = wide_t'(pz) - wide_t'(org[2]);
        pu = dot_q(ax_u[0], ax_u[1], ax_u[2], r0, r1, r2);
        pv = dot_q(ax_v[0], ax_v[1], ax_v[2], r0, r1, r2);
        m2u = dot_q(ax_u[0], ax_u[1], ax_u[2], ax_u[0], ax_u[1], ax_u[2]);
        m2v = dot_q(ax_v[0], ax_v[1], ax_v[2], ax_v[0], ax_v[1], ax_v[2]);
        dp = dot_q(ax_u[0], ax_u[1], ax_u[2], ax_v[0], ax_v[1], ax_v[2]);
        dm = dp < 0 ? -dp : dp;
        res = '0;
        clip = 1'b0;
        if (dm * 1000000 < (128'sd1 <<< FRAC_BITS))
        begin
            qu = m2u == 0 ? 128'sd0 : quot_q(pu, m2u);
            qv = m2v == 0 ? 128'sd0 : quot_q(pv, m2v);
        end
        else
        begin
            det = m2u * m2v - dp * dp;
            if (det == 0)
            begin
                res.singular = 1'b1;
                return res;
            end
            qu = quot_q(pu * m2v - pv * dp, det);
            qv = quot_q(pv * m2u - pu * dp, det);
        end
        res.u = clamp32(qu + base_to_q(base_u), clip);
        res.v = clamp32(qv + base_to_q(base_v), clip);
        res.clipped = clip;
        return res;
    endfunction

    assign pending = expected_uv.size();

    always @(posedge clk or negedge rst_n)
    begin
        uv_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ax_u[i] <= '0;
                ax_v[i] <= '0;
                org[i] <= '0;
            end
            base_u <= '0;
            base_v <= '0;
            fail_count <= 0;
            expected_uv.delete();
        end
        else
        begin
            if (vtx_valid && !vtx_stall)
            begin
                case (action)
                    ACT_U_AXIS:
                    begin
                        ax_u[0] <= x; ax_u[1] <= y; ax_u[2] <= z; base_u <= base;
                    end
                    ACT_V_AXIS:
                    begin
                        ax_v[0] <= x; ax_v[1] <= y; ax_v[2] <= z; base_v <= base;
                    end
                    ACT_ORIGIN:
                    begin
                        org[0] <= x; org[1] <= y; org[2] <= z;
                    end
                    ACT_PROJECT:
                        expected_uv.insert(expected_uv.size(), project_vertex(x, y, z));
                    default: ;
                endcase
            end
            if (uv_valid && !uv_stall)
            begin
                if (expected_uv.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result u=%0d v=%0d", u, v);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_uv.pop_front();
                    if (want.u !== u || want.v !== v || want.clipped !== clipped
                        || want.singular !== singular)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: exp u=%0d v=%0d clip=%b sing=%b,",
                                      " got u=%0d v=%0d clip=%b sing=%b"},
                                     want.u, want.v, want.clipped, want.singular,
                                     u, v, clipped, singular);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/tb_planar_uv_projector.sv
// Top of the planar UV projector testbench: clock, reset, stimulus and verdict.
// Depends on planar_uv_projector and uv_projection_checker.
module tb_planar_uv_projector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_U_AXIS = 2'd0;
    localparam logic [1:0] ACT_V_AXIS = 2'd1;
    localparam logic [1:0] ACT_ORIGIN = 2'd2;
    localparam logic [1:0] ACT_PROJECT = 2'd3;
    // covers the longest projection; allow for stalls several times over
    localparam int IDLE_LIMIT = 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               vtx_valid = 1'b0;
    logic               vtx_stall;
    logic [1:0]         action = ACT_ORIGIN;
    logic signed [31:0] x = '0, y = '0, z = '0, base = '0;
    logic               uv_valid;
    logic               uv_stall = 1'b0;
    logic signed [31:0] u, v;
    logic               clipped, singular;
    int                 fail_count, pending;
    int                 idle_cycles = 0;
    bit                 calm = 1'b0;

    always #6 clk = ~clk;

    planar_uv_projector i_dut (.*);
    uv_projection_checker i_chk (.*);

    always @(posedge clk)
    begin
        if ((vtx_valid && !vtx_stall) || (uv_valid && !uv_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        uv_stall <= !calm && ($urandom_range(99) < 36);

    function automatic logic signed [31:0] rand_coord(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'sh80000000;
            2: return 32'sh7fffffff;
            3: return 0;
            default: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
        endcase
    endfunction

    // one transaction; random idle first unless in the calm stretch
    task automatic send(input logic [1:0] act, input logic signed [31:0] px, py, pz, pb);
        if (!calm)
            while ($urandom_range(99) < 36)
            begin
                vtx_valid <= 1'b0;
                @(posedge clk);
            end
        vtx_valid <= 1'b1;
        action <= act;
        x <= px; y <= py; z <= pz; base <= pb;
        do
            @(posedge clk);
        while (vtx_stall);
    endtask

    task automatic send_axes(input bit skew);
        logic signed [31:0] a0, a1, a2;
        a0 = rand_coord($urandom_range(0, 6));
        a1 = rand_coord($urandom_range(3, 6));
        a2 = rand_coord($urandom_range(3, 6));
        send(ACT_U_AXIS, a0, a1, a2, rand_coord($urandom_range(0, 6)));
        if (skew)
            send(ACT_V_AXIS, rand_coord($urandom_range(0, 6)), rand_coord($urandom_range(3, 6)),
                 rand_coord($urandom_range(3, 6)), rand_coord($urandom_range(0, 6)));
        else
            send(ACT_V_AXIS, 0, a2, -a1, rand_coord($urandom_range(0, 6)));
    endtask

    initial
    begin
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // zero axes after reset
        send(ACT_PROJECT, 32'sh10000, 0, 0, 0);
        send(ACT_U_AXIS, 32'sh10000, 0, 0, 32'sh1000);
        send(ACT_V_AXIS, 0, 32'sh10000, 0, 32'sh7fffffff);
        send(ACT_ORIGIN, 32'sh80000000, 0, 32'sh7fffffff, 0);
        send(ACT_PROJECT, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
        send(ACT_PROJECT, 32'sh80000000, 32'sh7fffffff, 0, 0);
        send(ACT_V_AXIS, 0, 0, 0, 32'sh80000000);
        send(ACT_PROJECT, 32'sh12345, 32'sh6789a, 32'sh1, 0);
        // parallel axes: singular
        send(ACT_V_AXIS, 32'sh20000, 0, 0, 0);
        send(ACT_PROJECT, 32'sh30000, 32'sh40000, 0, 0);
        // skewed axes
        send(ACT_V_AXIS, 32'sh8000, 32'sh10000, 32'shffff, -32'sh800);
        send(ACT_PROJECT, -32'sh30000, 32'sh40000, 32'sh7fffffff, 0);
        send(ACT_U_AXIS, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        send(ACT_PROJECT, 32'sh1, -32'sh1, 32'sh55555555, 32'shffffffff);
        // sender pauses until every result is out
        vtx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        n = 0;
        while (n < 1430)
        begin
            calm = (n >= 300 && n < 450);
            case ($urandom_range(0, 9))
                0:
                begin
                    send_axes(1'b0);
                    n++;
                end
                1:
                begin
                    send_axes(1'b1);
                    n++;
                end
                2: send(ACT_ORIGIN, rand_coord($urandom_range(0, 6)),
                        rand_coord($urandom_range(0, 6)), rand_coord($urandom_range(0, 6)),
                        $urandom);
                3: send(2'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
                default: send(ACT_PROJECT, rand_coord($urandom_range(0, 6)),
                              rand_coord($urandom_range(0, 6)),
                              rand_coord($urandom_range(0, 6)), $urandom);
            endcase
            n++;
        end
        calm = 1'b0;
        vtx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
